### hdl/wcs_pkg.sv
// wcs_pkg: shared types and constants for the word_cpu_step block.
// No dependencies; used by hdl/word_cpu_step.sv.

package wcs_pkg;

  // Memory address width (8..16); registers stay 16 bits wide.
  localparam int ADDR_WIDTH = 16;
  localparam int MEM_DEPTH  = 1 << ADDR_WIDTH;
  localparam logic [ADDR_WIDTH-1:0] ADDR_LAST = '1;  // halt word

  // Request opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_EXEC  = 2'd2;

  // Special register numbers
  localparam logic [2:0] RG_ZERO = 3'd0;
  localparam logic [2:0] RG_MEM  = 3'd1;
  localparam logic [2:0] RG_ADDR = 3'd5;
  localparam logic [2:0] RG_JUMP = 3'd6;
  localparam logic [2:0] RG_PC   = 3'd7;

  // Instruction bit positions
  localparam int I_KIND  = 15;  // 1 = OP, 0 = LD
  localparam int I_OR    = 11;
  localparam int I_ZERO  = 10;
  localparam int I_HIGH  = 10;  // LD byte select
  localparam int I_INV   = 9;
  localparam int I_CARRY = 8;
  localparam int I_JNEG  = 1;
  localparam int I_JZERO = 0;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [15:0] data;
  } in_req_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [15:0] prog_counter;
    logic        halted;
    logic        zero_flag;
    logic        negative_flag;
  } out_req_t;

endpackage

### hdl/word_cpu_step.sv
// word_cpu_step: 16-bit word machine, host access port plus single-step execution.
// Depends on wcs_pkg (types, opcodes, register numbers, instruction fields).

// Each request returns exactly one result. Memory writes and reads may follow
// back to back; an execute request occupies the block through instruction
// fetch, read of the register-1 memory window at the address in register 5,
// then ALU and commit, since fetch and window read share the single read port
// and commit uses the single write port of the main memory. While an
// instruction is in flight in_ready is low; an execute request on a halted
// machine completes without a fetch and changes nothing. Memory contents are
// undefined after reset: the host loads the whole image, including the last
// word (the halt word), before any read or execute. The result register lets
// a new request be accepted in the cycle the previous result is taken.

module word_cpu_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wcs_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output wcs_pkg::out_req_t out_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  localparam int AW = wcs_pkg::ADDR_WIDTH;

  // Main memory: one write port, one registered read port
  logic [15:0]   mem [wcs_pkg::MEM_DEPTH];
  logic [15:0]   mem_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [15:0]   mem_wd;

  // Architectural state
  logic [15:0] regs_r [8];
  logic [15:0] regs_nxt [8];
  logic        zf_r, zf_nxt;
  logic        nf_r, nf_nxt;
  logic        halt_r, halt_nxt;

  // Sequencer
  logic [1:0]  state_r, state_nxt;
  logic [15:0] ins_r, ins_nxt;

  // Result slot
  logic              out_valid_r, out_valid_nxt;
  wcs_pkg::out_req_t out_r, out_nxt;
  logic              rd_sel_r, rd_sel_nxt;  // read_data comes from mem_q
  logic              load_out;

  // Execute datapath
  logic [15:0] op_a, op_b, alu_res, wb_val, ld_cur;
  logic        wb_en, take_jump;
  logic [2:0]  wb_dst;

  logic in_fire;

  // Register read with the zero and memory-window specials
  function automatic logic [15:0] reg_rd(input logic [2:0] sel);
    logic [15:0] v;
    case (sel)
      wcs_pkg::RG_ZERO: v = '0;
      wcs_pkg::RG_MEM:  v = mem_q;
      default:          v = regs_r[sel];
    endcase
    return v;
  endfunction

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    regs_nxt      = regs_r;
    zf_nxt        = zf_r;
    nf_nxt        = nf_r;
    halt_nxt      = halt_r;
    ins_nxt       = ins_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    rd_sel_nxt    = rd_sel_r;
    load_out      = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = '0;
    mem_re        = 1'b0;
    mem_ra        = '0;
    op_a          = '0;
    op_b          = '0;
    alu_res       = '0;
    ld_cur        = '0;
    wb_val        = '0;
    wb_en         = 1'b0;
    wb_dst        = wcs_pkg::RG_ZERO;
    take_jump     = 1'b0;

    if (in_fire) begin
      case (in_data.op)
        wcs_pkg::OP_WRITE: begin
          mem_we     = 1'b1;
          mem_wa     = in_data.addr[AW-1:0];
          mem_wd     = in_data.data;
          load_out   = 1'b1;
          rd_sel_nxt = 1'b0;
        end
        wcs_pkg::OP_READ: begin
          mem_re     = 1'b1;
          mem_ra     = in_data.addr[AW-1:0];
          load_out   = 1'b1;
          rd_sel_nxt = 1'b1;  // data shows up in mem_q next cycle
        end
        wcs_pkg::OP_EXEC: begin
          if (halt_r) begin
            load_out   = 1'b1;
            rd_sel_nxt = 1'b0;
          end else begin
            // fetch at PC, PC advances before any operand read
            mem_re                = 1'b1;
            mem_ra                = regs_r[wcs_pkg::RG_PC][AW-1:0];
            regs_nxt[wcs_pkg::RG_PC] = regs_r[wcs_pkg::RG_PC] + 16'd1;
            state_nxt             = S_FETCH;
          end
        end
        default: begin
          load_out   = 1'b1;
          rd_sel_nxt = 1'b0;
        end
      endcase
    end

    case (state_r)
      S_FETCH: begin
        // latch instruction, read the register-1 window unconditionally
        ins_nxt   = mem_q;
        mem_re    = 1'b1;
        mem_ra    = regs_r[wcs_pkg::RG_ADDR][AW-1:0];
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (ins_r[wcs_pkg::I_KIND]) begin
          op_a = reg_rd(ins_r[7:5]);
          op_b = reg_rd(ins_r[4:2]);
          if (ins_r[wcs_pkg::I_ZERO])  op_a = '0;
          if (ins_r[wcs_pkg::I_INV])   op_a = ~op_a;
          if (ins_r[wcs_pkg::I_CARRY]) op_a = op_a + 16'd1;
          alu_res = ins_r[wcs_pkg::I_OR] ? (op_a | op_b) : (op_a + op_b);
          zf_nxt  = (alu_res == 16'd0);
          nf_nxt  = alu_res[15];
          if (ins_r[wcs_pkg::I_JNEG] || ins_r[wcs_pkg::I_JZERO]) begin
            take_jump = (ins_r[wcs_pkg::I_JNEG] && alu_res[15]) ||
                        (ins_r[wcs_pkg::I_JZERO] && (alu_res == 16'd0));
          end else begin
            wb_en  = 1'b1;
            wb_dst = ins_r[14:12];
            wb_val = alu_res;
          end
        end else begin
          // LD: replace one byte of the destination
          ld_cur = reg_rd(ins_r[14:12]);
          wb_en  = 1'b1;
          wb_dst = ins_r[14:12];
          wb_val = ins_r[wcs_pkg::I_HIGH] ? {ins_r[7:0], ld_cur[7:0]}
                                         : {ld_cur[15:8], ins_r[7:0]};
        end

        if (take_jump) begin
          regs_nxt[wcs_pkg::RG_PC] = regs_r[wcs_pkg::RG_JUMP];
        end
        if (wb_en) begin
          case (wb_dst)
            wcs_pkg::RG_ZERO: ;
            wcs_pkg::RG_MEM: begin
              mem_we = 1'b1;
              mem_wa = regs_r[wcs_pkg::RG_ADDR][AW-1:0];
              mem_wd = wb_val;
            end
            default: regs_nxt[wb_dst] = wb_val;
          endcase
        end

        load_out   = 1'b1;
        rd_sel_nxt = 1'b0;
        state_nxt  = S_IDLE;
      end
      default: ;
    endcase

    // halt word shadow follows every write to the last address
    if (mem_we && (mem_wa == wcs_pkg::ADDR_LAST)) begin
      halt_nxt = (mem_wd != 16'd0);
    end

    if (load_out) begin
      out_valid_nxt         = 1'b1;
      out_nxt.read_data     = '0;
      out_nxt.prog_counter  = regs_nxt[wcs_pkg::RG_PC];
      out_nxt.halted        = halt_nxt;
      out_nxt.zero_flag     = zf_nxt;
      out_nxt.negative_flag = nf_nxt;
    end
  end

  // Main memory; no reset, host loads the image
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      zf_r        <= 1'b0;
      nf_r        <= 1'b0;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
      rd_sel_r    <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      zf_r        <= zf_nxt;
      nf_r        <= nf_nxt;
      halt_r      <= halt_nxt;
      out_valid_r <= out_valid_nxt;
      rd_sel_r    <= rd_sel_nxt;
      regs_r      <= regs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ins_r <= ins_nxt;
    out_r <= out_nxt;
  end

  // mem_q only moves on an accepted request or inside an instruction, both
  // of which need the result slot drained, so a pending read result holds.
  assign out_valid              = out_valid_r;
  assign out_data.read_data     = rd_sel_r ? mem_q : out_r.read_data;
  assign out_data.prog_counter  = out_r.prog_counter;
  assign out_data.halted        = out_r.halted;
  assign out_data.zero_flag     = out_r.zero_flag;
  assign out_data.negative_flag = out_r.negative_flag;

  // Interlock: nothing is taken while an instruction is in flight
  a_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("request accepted during instruction");

  // Commit always finds the result slot empty
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> !out_valid_r)
    else $error("result slot busy at commit");

  // Fetch is always followed by commit
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH) |=> (state_r == S_EXEC))
    else $error("sequencer skipped commit");

  // Host write of the halt word updates the halt shadow
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.op == wcs_pkg::OP_WRITE) &&
     (in_data.addr[AW-1:0] == wcs_pkg::ADDR_LAST))
    |=> (halt_r == ($past(in_data.data) != 16'd0)))
    else $error("halt shadow out of step");

endmodule
